// ----- design/csp_pkg.sv -----
package csp_pkg;

    typedef logic [2:0] t_form;

    localparam t_form FORM_EMPTY     = 3'd0;
    localparam t_form FORM_HEX       = 3'd1;
    localparam t_form FORM_PREFIX    = 3'd2;
    localparam t_form FORM_COMP_RGB  = 3'd3;
    localparam t_form FORM_COMP_RGBA = 3'd4;
    localparam t_form FORM_OP_INT    = 3'd5;
    localparam t_form FORM_OP_FRAC   = 3'd6;
    localparam t_form FORM_DONE      = 3'd7;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LG     = 8'h67;
    localparam logic [7:0] CH_LR     = 8'h72;

    localparam logic [3:0] HEX_COUNT_RGB    = 4'd3;
    localparam logic [3:0] HEX_COUNT_ARGB   = 4'd4;
    localparam logic [3:0] HEX_COUNT_RRGGBB = 4'd6;
    localparam logic [3:0] HEX_COUNT_FULL   = 4'd8;

    localparam logic [3:0] PFX_R  = 4'd1;
    localparam logic [3:0] PFX_RG = 4'd2;
    localparam logic [3:0] PFX_RGB  = 4'd3;
    localparam logic [3:0] PFX_RGBA = 4'd4;

    function automatic longint unsigned pow10(input int unsigned n);
        longint unsigned p;
        p = 64'd1;
        for (int unsigned i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

// ----- design/color_string_parser.sv -----
// Color string parser: takes one ASCII character per item with an end flag and, on
// the item flagged as last, gives one ARGB8888 word and a parse_ok flag (color is 0
// when parse_ok is 0). Spaces are ignored. Accepted: #RGB, #ARGB, #RRGGBB, #AARRGGBB
// and lowercase rgb(r,g,b) / rgba(r,g,b,o); components clamp to 255, opacity 0..1
// is rounded half up to alpha using FRACTION_DIGITS fraction digits (later digits
// are ignored). One character is accepted every cycle while o_stall is low. After
// its last character is accepted, a result moves through registers r_s1 and r_out:
// r_s1 holds the finished parse, r_out takes the opacity-to-alpha divide done as a
// reciprocal multiply. The parser state clears itself after each last character.
module color_string_parser #(
    parameter int FRACTION_DIGITS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_argb_color,
    output logic        o_parse_ok
);

    localparam longint unsigned Scale = csp_pkg::pow10(FRACTION_DIGITS);
    localparam int XW   = $clog2(64'd256 * Scale);
    localparam int YW   = XW - FRACTION_DIGITS;
    localparam longint unsigned Pow5 = Scale >> FRACTION_DIGITS;
    localparam int L5   = $clog2(Pow5);
    localparam int KSH  = YW + L5;
    localparam int MW   = YW + 1;
    localparam longint unsigned Recip = ((64'd1 << KSH) + Pow5 - 64'd1) / Pow5;
    localparam int FcW  = $clog2(FRACTION_DIGITS + 1);
    localparam int WN   = 2 ** FcW;
    localparam logic [XW-1:0] XHalf = XW'(Scale / 64'd2);
    localparam logic [XW-1:0] XFull = XW'(64'd255 * Scale);
    localparam logic [MW-1:0] RecipW = MW'(Recip);

    logic [XW-1:0] w_weight [WN];

    genvar gk;
    generate
        for (gk = 0; gk < WN; gk++) begin : g_weight
            if (gk < FRACTION_DIGITS) begin : g_used
                assign w_weight[gk] =
                    XW'(64'd255 * csp_pkg::pow10(FRACTION_DIGITS - 1 - gk));
            end else begin : g_pad
                assign w_weight[gk] = '0;
            end
        end
    endgenerate

    csp_pkg::t_form r_form, n_form;
    logic [3:0]     r_cnt, n_cnt;
    logic [31:0]    r_hex, n_hex;
    logic [1:0]     r_idx, n_idx;
    logic [8:0]     r_comp, n_comp;
    logic [7:0]     r_ch [3];
    logic [7:0]     n_ch [3];
    logic [XW-1:0]  r_t, n_t;
    logic [XW-1:0]  r_x, n_x;
    logic [FcW-1:0] r_fcnt, n_fcnt;
    logic           r_fnz, n_fnz;
    logic           r_err, n_err;
    logic           r_seen, n_seen;

    logic           r_s1_valid;
    logic           r_s1_ok;
    logic           r_s1_done;
    logic [31:0]    r_s1_color;
    logic [XW-1:0]  r_s1_x;
    logic           r_out_valid;
    logic [31:0]    r_out_color;
    logic           r_out_ok;

    logic           w_s2_load;
    logic           w_s1_free;
    logic           w_accept;
    logic [7:0]     c;
    logic           w_is_dig;
    logic [3:0]     w_dig;
    logic           w_hex_v;
    logic [3:0]     w_hex_d;
    logic [11:0]    w_cv;
    logic [7:0]     w_chan;
    logic [XW-1:0]  w_fin_x;
    logic           w_fin_bad;
    logic           w_rgba;
    logic           w_hex_ok;
    logic [31:0]    w_hex_color;
    logic [YW-1:0]  w_y;
    logic [YW+MW-1:0] w_prod;
    logic [7:0]     w_alpha;

    assign w_s2_load = !r_out_valid || !i_stall;
    assign w_s1_free = !r_s1_valid || w_s2_load;
    assign o_stall   = !w_s1_free;
    assign w_accept  = i_valid && w_s1_free;

    assign c        = i_char_code;
    assign w_is_dig = (c >= csp_pkg::CH_ZERO) && (c <= csp_pkg::CH_NINE);
    assign w_dig    = c[3:0];
    assign w_cv     = 12'(r_comp) * 12'd10 + 12'(w_dig);
    assign w_chan   = r_comp[8] ? 8'hFF : r_comp[7:0];
    assign w_fin_x  = (r_comp[0] ? XFull : r_t) + XHalf;
    assign w_fin_bad = r_comp[0] && r_fnz;
    assign w_rgba   = (r_form == csp_pkg::FORM_COMP_RGBA);

    always_comb begin
        w_hex_v = 1'b1;
        w_hex_d = 4'd0;
        if (w_is_dig) begin
            w_hex_d = c[3:0];
        end else if ((c >= csp_pkg::CH_LA && c <= csp_pkg::CH_LF) ||
                     (c >= csp_pkg::CH_UA && c <= csp_pkg::CH_UF)) begin
            w_hex_d = c[3:0] + 4'd9;
        end else begin
            w_hex_v = 1'b0;
        end
    end

    always_comb begin
        n_form = r_form;
        n_cnt  = r_cnt;
        n_hex  = r_hex;
        n_idx  = r_idx;
        n_comp = r_comp;
        n_ch   = r_ch;
        n_t    = r_t;
        n_x    = r_x;
        n_fcnt = r_fcnt;
        n_fnz  = r_fnz;
        n_err  = r_err;
        n_seen = r_seen;
        if (c != csp_pkg::CH_SPACE && !r_err) begin
            unique case (r_form)
                csp_pkg::FORM_EMPTY: begin
                    priority if (c == csp_pkg::CH_HASH) begin
                        n_form = csp_pkg::FORM_HEX;
                        n_cnt  = 4'd0;
                    end else if (c == csp_pkg::CH_LR) begin
                        n_form = csp_pkg::FORM_PREFIX;
                        n_cnt  = csp_pkg::PFX_R;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                csp_pkg::FORM_HEX: begin
                    if (w_hex_v) begin
                        n_hex = {r_hex[27:0], w_hex_d};
                        if (r_cnt != 4'hF) begin
                            n_cnt = r_cnt + 4'd1;
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end
                csp_pkg::FORM_PREFIX: begin
                    priority if (r_cnt == csp_pkg::PFX_R && c == csp_pkg::CH_LG) begin
                        n_cnt = csp_pkg::PFX_RG;
                    end else if (r_cnt == csp_pkg::PFX_RG && c == csp_pkg::CH_LB) begin
                        n_cnt = csp_pkg::PFX_RGB;
                    end else if (r_cnt == csp_pkg::PFX_RGB && c == csp_pkg::CH_LA) begin
                        n_cnt = csp_pkg::PFX_RGBA;
                    end else if (r_cnt == csp_pkg::PFX_RGB && c == csp_pkg::CH_LPAREN) begin
                        n_form = csp_pkg::FORM_COMP_RGB;
                        n_comp = '0;
                        n_cnt  = 4'd0;
                        n_seen = 1'b0;
                    end else if (r_cnt == csp_pkg::PFX_RGBA && c == csp_pkg::CH_LPAREN) begin
                        n_form = csp_pkg::FORM_COMP_RGBA;
                        n_comp = '0;
                        n_cnt  = 4'd0;
                        n_seen = 1'b0;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                csp_pkg::FORM_COMP_RGB, csp_pkg::FORM_COMP_RGBA: begin
                    priority if (w_is_dig) begin
                        n_comp = (w_cv > 12'd256) ? 9'd256 : w_cv[8:0];
                        n_seen = 1'b1;
                        if (r_cnt != 4'hF) begin
                            n_cnt = r_cnt + 4'd1;
                        end
                    end else if (c == csp_pkg::CH_PLUS && r_cnt == 4'd0) begin
                        n_cnt = 4'd1;
                    end else if (c == csp_pkg::CH_COMMA && r_seen && r_idx < 2'd2) begin
                        n_ch[r_idx] = w_chan;
                        n_idx  = r_idx + 2'd1;
                        n_comp = '0;
                        n_cnt  = 4'd0;
                        n_seen = 1'b0;
                    end else if (c == csp_pkg::CH_COMMA && r_seen && w_rgba &&
                                 r_idx == 2'd2) begin
                        n_ch[2] = w_chan;
                        n_comp  = '0;
                        n_cnt   = 4'd0;
                        n_seen  = 1'b0;
                        n_form  = csp_pkg::FORM_OP_INT;
                    end else if (c == csp_pkg::CH_RPAREN && r_seen && !w_rgba &&
                                 r_idx == 2'd2) begin
                        n_ch[2] = w_chan;
                        n_x     = XFull + XHalf;
                        n_form  = csp_pkg::FORM_DONE;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                csp_pkg::FORM_OP_INT: begin
                    priority if (!r_seen && (c == csp_pkg::CH_ZERO || c == csp_pkg::CH_ONE)) begin
                        n_comp = {8'd0, c[0]};
                        n_seen = 1'b1;
                    end else if (r_seen && c == csp_pkg::CH_DOT) begin
                        n_form = csp_pkg::FORM_OP_FRAC;
                        n_seen = 1'b0;
                    end else if (r_seen && c == csp_pkg::CH_RPAREN && !w_fin_bad) begin
                        n_x    = w_fin_x;
                        n_form = csp_pkg::FORM_DONE;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                csp_pkg::FORM_OP_FRAC: begin
                    priority if (w_is_dig) begin
                        if (r_fcnt < FcW'(FRACTION_DIGITS)) begin
                            n_t    = r_t + XW'(w_weight[r_fcnt] * XW'(w_dig));
                            n_fnz  = r_fnz || (w_dig != 4'd0);
                            n_fcnt = r_fcnt + FcW'(1);
                        end
                        n_seen = 1'b1;
                    end else if (r_seen && c == csp_pkg::CH_RPAREN && !w_fin_bad) begin
                        n_x    = w_fin_x;
                        n_form = csp_pkg::FORM_DONE;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end
    end

    assign w_hex_ok = (n_form == csp_pkg::FORM_HEX) &&
                      (n_cnt == csp_pkg::HEX_COUNT_RGB || n_cnt == csp_pkg::HEX_COUNT_ARGB ||
                       n_cnt == csp_pkg::HEX_COUNT_RRGGBB || n_cnt == csp_pkg::HEX_COUNT_FULL);

    always_comb begin
        unique case (n_cnt)
            csp_pkg::HEX_COUNT_RGB:
                w_hex_color = {8'hFF, {2{n_hex[11:8]}}, {2{n_hex[7:4]}}, {2{n_hex[3:0]}}};
            csp_pkg::HEX_COUNT_ARGB:
                w_hex_color = {{2{n_hex[15:12]}}, {2{n_hex[11:8]}},
                               {2{n_hex[7:4]}}, {2{n_hex[3:0]}}};
            csp_pkg::HEX_COUNT_RRGGBB:
                w_hex_color = {8'hFF, n_hex[23:0]};
            default:
                w_hex_color = n_hex;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_form <= csp_pkg::FORM_EMPTY;
            r_cnt  <= '0;
            r_hex  <= '0;
            r_idx  <= '0;
            r_comp <= '0;
            r_ch   <= '{default: '0};
            r_t    <= '0;
            r_x    <= '0;
            r_fcnt <= '0;
            r_fnz  <= 1'b0;
            r_err  <= 1'b0;
            r_seen <= 1'b0;
        end else if (w_accept) begin
            if (i_end_of_string) begin
                r_form <= csp_pkg::FORM_EMPTY;
                r_cnt  <= '0;
                r_hex  <= '0;
                r_idx  <= '0;
                r_comp <= '0;
                r_ch   <= '{default: '0};
                r_t    <= '0;
                r_x    <= '0;
                r_fcnt <= '0;
                r_fnz  <= 1'b0;
                r_err  <= 1'b0;
                r_seen <= 1'b0;
            end else begin
                r_form <= n_form;
                r_cnt  <= n_cnt;
                r_hex  <= n_hex;
                r_idx  <= n_idx;
                r_comp <= n_comp;
                r_ch   <= n_ch;
                r_t    <= n_t;
                r_x    <= n_x;
                r_fcnt <= n_fcnt;
                r_fnz  <= n_fnz;
                r_err  <= n_err;
                r_seen <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && i_end_of_string) begin
                r_s1_valid <= 1'b1;
            end else if (w_s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s2_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_end_of_string) begin
            r_s1_ok    <= !n_err && (w_hex_ok || n_form == csp_pkg::FORM_DONE);
            r_s1_done  <= (n_form == csp_pkg::FORM_DONE);
            r_s1_color <= (n_form == csp_pkg::FORM_DONE) ?
                          {8'h00, n_ch[0], n_ch[1], n_ch[2]} : w_hex_color;
            r_s1_x     <= n_x;
        end
        if (w_s2_load && r_s1_valid) begin
            r_out_ok    <= r_s1_ok;
            r_out_color <= !r_s1_ok ? 32'd0 :
                           r_s1_done ? {w_alpha, r_s1_color[23:0]} : r_s1_color;
        end
    end

    // alpha = floor(x / 10^D): shift out 2^D, then multiply by reciprocal of 5^D
    assign w_y     = r_s1_x[XW-1:FRACTION_DIGITS];
    assign w_prod  = (YW+MW)'(w_y) * (YW+MW)'(RecipW);
    assign w_alpha = w_prod[KSH +: 8];

    assign o_valid      = r_out_valid;
    assign o_argb_color = r_out_color;
    assign o_parse_ok   = r_out_ok;

`ifndef NO_ASSERTIONS
    a_stall_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid))
        else $error("stall without pending result");

    a_last_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_end_of_string) |=> r_s1_valid)
        else $error("last character lost");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_parse_ok) |-> (o_argb_color == 32'd0))
        else $error("failed parse carries a color");

    a_fcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= FcW'(FRACTION_DIGITS))
        else $error("fraction digit count overflow");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_end_of_string) |=> (r_form == csp_pkg::FORM_EMPTY && !r_err))
        else $error("parser not cleared after last character");
`endif

endmodule

// ----- tb/color_string_parser_checker.sv -----
`timescale 1ns / 100ps

module color_string_parser_checker #(
    parameter int FRACTION_DIGITS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_string,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_argb_color,
    input  logic        i_parse_ok,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] color;
        logic        ok;
    } t_color_result;

    t_color_result color_q[$];
    t_color_result exp_color;
    int            fail_cnt = 0;
    int            pend_cnt = 0;

    // parser state
    csp_pkg::t_form pr_form;
    logic [3:0]  pr_count;
    logic [31:0] pr_acc;
    logic [1:0]  pr_idx;
    logic [8:0]  pr_val;
    logic [7:0]  pr_chan[3];
    logic [19:0] pr_frac;
    int          pr_fdig;
    logic        pr_err;
    logic        pr_seen;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pend_cnt;

    task automatic clear_parse();
        pr_form  = csp_pkg::FORM_EMPTY;
        pr_count = '0;
        pr_acc   = '0;
        pr_idx   = '0;
        pr_val   = '0;
        pr_chan[0] = '0;
        pr_chan[1] = '0;
        pr_chan[2] = '0;
        pr_frac  = '0;
        pr_fdig  = 0;
        pr_err   = 1'b0;
        pr_seen  = 1'b0;
    endtask

    task automatic start_component();
        pr_val   = '0;
        pr_count = '0;
        pr_seen  = 1'b0;
    endtask

    function automatic logic [7:0] clamp_channel(input logic [8:0] v);
        return (v > 9'd255) ? 8'hFF : v[7:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= csp_pkg::CH_ZERO) && (c <= csp_pkg::CH_NINE);
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (is_digit(c)) return int'(c - csp_pkg::CH_ZERO);
        if (c >= csp_pkg::CH_LA && c <= csp_pkg::CH_LF) return int'(c - csp_pkg::CH_LA) + 10;
        if (c >= csp_pkg::CH_UA && c <= csp_pkg::CH_UF) return int'(c - csp_pkg::CH_UA) + 10;
        return -1;
    endfunction

    function automatic logic [31:0] expand_short(input logic [31:0] nib, input int n);
        logic [31:0] word;
        word = '0;
        for (int i = n - 1; i >= 0; i--) begin
            word = (word << 8) | (32'(nib[4*i +: 4]) * 32'h11);
        end
        return word;
    endfunction

    task automatic finish_opacity();
        longint unsigned scale;
        longint unsigned frac;
        longint unsigned num;
        longint unsigned alpha;
        scale = 64'd1;
        repeat (FRACTION_DIGITS) scale = scale * 64'd10;
        frac = 64'(pr_frac);
        repeat (FRACTION_DIGITS - pr_fdig) frac = frac * 64'd10;
        num = 64'(pr_val) * scale + frac;
        if (num > scale) begin
            pr_err = 1'b1;
        end else begin
            alpha   = (num * 64'd255 + scale / 64'd2) / scale;
            pr_acc  = {alpha[7:0], pr_chan[0], pr_chan[1], pr_chan[2]};
            pr_form = csp_pkg::FORM_DONE;
        end
    endtask

    task automatic take_component(input logic [7:0] c);
        logic rgba;
        int   v;
        rgba = (pr_form == csp_pkg::FORM_COMP_RGBA);
        if (is_digit(c)) begin
            v = int'(pr_val) * 10 + int'(c - csp_pkg::CH_ZERO);
            pr_val  = (v > 256) ? 9'd256 : 9'(v);
            pr_seen = 1'b1;
            if (pr_count < 4'd15) pr_count++;
        end else if (c == csp_pkg::CH_PLUS && pr_count == 4'd0) begin
            pr_count = 4'd1;
        end else if (c == csp_pkg::CH_COMMA && pr_seen && pr_idx < 2'd2) begin
            pr_chan[pr_idx] = clamp_channel(pr_val);
            pr_idx++;
            start_component();
        end else if (c == csp_pkg::CH_COMMA && pr_seen && rgba && pr_idx == 2'd2) begin
            pr_chan[2] = clamp_channel(pr_val);
            start_component();
            pr_form = csp_pkg::FORM_OP_INT;
        end else if (c == csp_pkg::CH_RPAREN && pr_seen && !rgba && pr_idx == 2'd2) begin
            pr_chan[2] = clamp_channel(pr_val);
            pr_acc  = {8'hFF, pr_chan[0], pr_chan[1], pr_chan[2]};
            pr_form = csp_pkg::FORM_DONE;
        end else begin
            pr_err = 1'b1;
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        int d;
        case (pr_form)
            csp_pkg::FORM_EMPTY: begin
                if (c == csp_pkg::CH_HASH) begin
                    pr_form  = csp_pkg::FORM_HEX;
                    pr_count = '0;
                end else if (c == csp_pkg::CH_LR) begin
                    pr_form  = csp_pkg::FORM_PREFIX;
                    pr_count = csp_pkg::PFX_R;
                end else begin
                    pr_err = 1'b1;
                end
            end
            csp_pkg::FORM_HEX: begin
                d = hex_value(c);
                if (d < 0) begin
                    pr_err = 1'b1;
                end else begin
                    pr_acc = {pr_acc[27:0], 4'(d)};
                    if (pr_count < 4'd15) pr_count++;
                end
            end
            csp_pkg::FORM_PREFIX: begin
                if (pr_count == csp_pkg::PFX_R && c == csp_pkg::CH_LG) begin
                    pr_count = csp_pkg::PFX_RG;
                end else if (pr_count == csp_pkg::PFX_RG && c == csp_pkg::CH_LB) begin
                    pr_count = csp_pkg::PFX_RGB;
                end else if (pr_count == csp_pkg::PFX_RGB && c == csp_pkg::CH_LA) begin
                    pr_count = csp_pkg::PFX_RGBA;
                end else if (pr_count == csp_pkg::PFX_RGB && c == csp_pkg::CH_LPAREN) begin
                    pr_form = csp_pkg::FORM_COMP_RGB;
                    start_component();
                end else if (pr_count == csp_pkg::PFX_RGBA && c == csp_pkg::CH_LPAREN) begin
                    pr_form = csp_pkg::FORM_COMP_RGBA;
                    start_component();
                end else begin
                    pr_err = 1'b1;
                end
            end
            csp_pkg::FORM_COMP_RGB, csp_pkg::FORM_COMP_RGBA: begin
                take_component(c);
            end
            csp_pkg::FORM_OP_INT: begin
                if (!pr_seen && (c == csp_pkg::CH_ZERO || c == csp_pkg::CH_ONE)) begin
                    pr_val  = 9'(c - csp_pkg::CH_ZERO);
                    pr_seen = 1'b1;
                end else if (pr_seen && c == csp_pkg::CH_DOT) begin
                    pr_form = csp_pkg::FORM_OP_FRAC;
                    pr_seen = 1'b0;
                end else if (pr_seen && c == csp_pkg::CH_RPAREN) begin
                    finish_opacity();
                end else begin
                    pr_err = 1'b1;
                end
            end
            csp_pkg::FORM_OP_FRAC: begin
                if (is_digit(c)) begin
                    if (pr_fdig < FRACTION_DIGITS) begin
                        pr_frac = pr_frac * 20'd10 + 20'(c - csp_pkg::CH_ZERO);
                        pr_fdig++;
                    end
                    pr_seen = 1'b1;
                end else if (pr_seen && c == csp_pkg::CH_RPAREN) begin
                    finish_opacity();
                end else begin
                    pr_err = 1'b1;
                end
            end
            default: begin
                pr_err = 1'b1;
            end
        endcase
    endtask

    function automatic t_color_result string_color();
        t_color_result res;
        res.color = '0;
        res.ok    = 1'b0;
        if (!pr_err && pr_form == csp_pkg::FORM_HEX) begin
            res.ok = 1'b1;
            case (pr_count)
                csp_pkg::HEX_COUNT_RGB:
                    res.color = 32'hFF00_0000 | expand_short(pr_acc, 3);
                csp_pkg::HEX_COUNT_ARGB:   res.color = expand_short(pr_acc, 4);
                csp_pkg::HEX_COUNT_RRGGBB: res.color = 32'hFF00_0000 | pr_acc;
                csp_pkg::HEX_COUNT_FULL:   res.color = pr_acc;
                default:                   res.ok = 1'b0;
            endcase
        end else if (!pr_err && pr_form == csp_pkg::FORM_DONE) begin
            res.color = pr_acc;
            res.ok    = 1'b1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            color_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (color_q.size() == 0) begin
                    $error("unexpected result: argb_color %h parse_ok %b",
                           i_argb_color, i_parse_ok);
                    fail_cnt++;
                end else begin
                    exp_color = color_q.pop_front();
                    if (i_argb_color !== exp_color.color) begin
                        $error("argb_color mismatch: expected %h, got %h",
                               exp_color.color, i_argb_color);
                        fail_cnt++;
                    end
                    if (i_parse_ok !== exp_color.ok) begin
                        $error("parse_ok mismatch: expected %b, got %b",
                               exp_color.ok, i_parse_ok);
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_char_code != csp_pkg::CH_SPACE && !pr_err) parse_char(i_char_code);
                if (i_end_of_string) begin
                    color_q.push_back(string_color());
                    clear_parse();
                end
            end
        end
        pend_cnt = color_q.size();
    end

endmodule

// ----- tb/tb_color_string_parser.sv -----
`timescale 1ns / 100ps

module tb_color_string_parser;

    localparam int FRAC_DIGITS = 6;
    localparam int PHASE_CHARS = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_char_code;
    logic        i_end_of_string;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_argb_color;
    logic        o_parse_ok;

    int          fail_count;
    int          pending;
    int          idle_pct;
    int          stall_pct;
    int          char_total;
    int          str_total;
    logic [7:0]  text_q[$];

    color_string_parser #(
        .FRACTION_DIGITS(FRAC_DIGITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .i_end_of_string(i_end_of_string),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_argb_color   (o_argb_color),
        .o_parse_ok     (o_parse_ok)
    );

    color_string_parser_checker #(
        .FRACTION_DIGITS(FRAC_DIGITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_char_code    (i_char_code),
        .i_end_of_string(i_end_of_string),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_argb_color   (o_argb_color),
        .i_parse_ok     (o_parse_ok),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("color_string_parser test failed");
        $finish;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_char_code     <= c;
        i_end_of_string <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        char_total++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
        str_total++;
    endtask

    task automatic send_string();
        for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
        str_total++;
    endtask

    // occasional space ahead of each char
    task automatic put(input logic [7:0] c);
        if ($urandom_range(99) < 6) text_q.push_back(csp_pkg::CH_SPACE);
        text_q.push_back(c);
    endtask

    task automatic put_hex();
        int n;
        int r;
        put(csp_pkg::CH_HASH);
        r = $urandom_range(3);
        n = (r == 0) ? 3 : (r == 1) ? 4 : (r == 2) ? 6 : 8;
        if ($urandom_range(9) == 0) n = $urandom_range(0, 11);
        repeat (n) begin
            r = $urandom_range(21);
            if (r < 10) put(csp_pkg::CH_ZERO + 8'(r));
            else if (r < 16) put(csp_pkg::CH_LA + 8'(r - 10));
            else put(csp_pkg::CH_UA + 8'(r - 16));
        end
    endtask

    task automatic put_number();
        int n;
        if ($urandom_range(3) == 0) put(csp_pkg::CH_PLUS);
        n = ($urandom_range(6) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
        repeat (n) put(csp_pkg::CH_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic put_opacity();
        int   n;
        logic one;
        one = 1'($urandom_range(1));
        put(one ? csp_pkg::CH_ONE : csp_pkg::CH_ZERO);
        if ($urandom_range(2) != 0) begin
            put(csp_pkg::CH_DOT);
            n = $urandom_range(1, 9);
            repeat (n) begin
                if (one && $urandom_range(1)) put(csp_pkg::CH_ZERO);
                else put(csp_pkg::CH_ZERO + 8'($urandom_range(9)));
            end
        end
    endtask

    task automatic put_rgb(input logic rgba);
        put(csp_pkg::CH_LR);
        put(csp_pkg::CH_LG);
        put(csp_pkg::CH_LB);
        if (rgba) put(csp_pkg::CH_LA);
        put(csp_pkg::CH_LPAREN);
        put_number();
        put(csp_pkg::CH_COMMA);
        put_number();
        put(csp_pkg::CH_COMMA);
        put_number();
        if (rgba) begin
            put(csp_pkg::CH_COMMA);
            put_opacity();
        end
        put(csp_pkg::CH_RPAREN);
    endtask

    // mostly well-formed strings, some corrupted, some pure noise
    task automatic make_string();
        int w;
        int f;
        int pos;
        text_q.delete();
        w = $urandom_range(99);
        if (w < 90) begin
            f = $urandom_range(2);
            if (f == 0) put_hex();
            else put_rgb(f == 2);
            if (w >= 75) begin
                case ($urandom_range(2))
                    0: begin
                        pos = $urandom_range(text_q.size() - 1);
                        text_q[pos] = 8'($urandom_range(255));
                    end
                    1: if (text_q.size() > 1) void'(text_q.pop_back());
                    default: text_q.push_back(8'($urandom_range(255)));
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(19) == 0) text_q.push_back(csp_pkg::CH_SPACE);
    endtask

    initial begin
        int phase_start;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_char_code     = '0;
        i_end_of_string = 1'b0;
        i_stall         = 1'b0;
        idle_pct        = 0;
        stall_pct       = 0;
        char_total      = 0;
        str_total       = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_text("#fff");
        send_text("#0A1b");
        send_text("#FfEeDd");
        send_text("#12345678");
        send_text("# 9 a B c");
        send_text("#12345");
        send_text("rgb(255,0,+300)");
        send_text("rgba( 0, 12,+99999 ,0.5)");
        send_text("rgba(1,2,3,1)");
        send_text("rgba(4,5,6,0.0019607843)");
        send_text("rgba(7,8,9,1.5)");
        send_text("rgba(1,1,1,1.0000004)");
        send_text("rgba(1,2,3,.5)");
        send_text("rgb(1,2,3)x");
        send_text("RGB(1,2,3)");
        send_text("rgb(,1,2)");
        send_text(" ");
        send_char(8'h80, 1'b0);
        send_char(8'hFF, 1'b1);
        str_total++;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            phase_start = char_total;
            while (char_total - phase_start < PHASE_CHARS) begin
                make_string();
                send_string();
            end
        end

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Sent %0d strings (%0d chars): hex, rgb and rgba forms, spaces,",
                 str_total, char_total);
        $display("corrupted strings and noise, under four idle and stall mixes.");
        if (fail_count == 0) begin
            $display("color_string_parser test passed");
        end else begin
            $display("color_string_parser test failed");
        end
        $finish;
    end

endmodule
